FILE: src/wgdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgdd_pkg
// Shared types and constants of the wait-graph deadlock detector.
// ----------------------------------------------------------------------------
package wgdd_pkg;

   // default sizes of the two bit matrices
   localparam int DEF_NUM_PROCS     = 8;
   localparam int DEF_NUM_RESOURCES = 8;

   // fixed field widths of the request channel
   localparam int MODE_W = 2;
   localparam int PIDX_W = 3;
   localparam int RIDX_W = 3;

   // event kinds
   localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ASSIGN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_SCAN,
      ST_SCAN_END
   } state_type;

   // control from the sequencer to the peeling unit
   typedef struct packed {
      logic init;       // all nodes live, change flag cleared
      logic proc_vld;   // a process row is on the read data
      logic res_vld;    // a resource row is on the read data
      logic clear_chg;  // a new pass starts
   } peel_ctl_type;

endpackage

FILE: src/wgdd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgdd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wgdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/wgdd_peel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgdd_peel
// Live-node masks of the cycle search: drops each node that has no edge to a
// node still live, one row per cycle, and records whether a pass changed
// anything.
// ----------------------------------------------------------------------------
module wgdd_peel
   import wgdd_pkg::*;
#(
   parameter int NUM_PROCS     = DEF_NUM_PROCS,
   parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
   localparam int PAW          = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
   localparam int RAW          = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  peel_ctl_type             ctl,
   input  logic [PAW-1:0]           proc_row,
   input  logic [RAW-1:0]           res_row,
   input  logic [NUM_RESOURCES-1:0] wait_row,
   input  logic [NUM_PROCS-1:0]     held_row,
   output logic                     changed,
   output logic                     cycle_found
);

   logic [NUM_PROCS-1:0]     live_p_ff, live_p_in;
   logic [NUM_RESOURCES-1:0] live_r_ff, live_r_in;
   logic                     chg_ff, chg_in;
   logic                     proc_hit;
   logic                     res_hit;

   // a node with no out-edge to a live node leaves the graph
   assign proc_hit = ctl.proc_vld && live_p_ff[proc_row] && ((wait_row & live_r_ff) == '0);
   assign res_hit  = ctl.res_vld && live_r_ff[res_row] && ((held_row & live_p_ff) == '0);

   always_comb begin
      live_p_in = live_p_ff;
      live_r_in = live_r_ff;
      chg_in    = chg_ff | proc_hit | res_hit;
      if (ctl.init) begin
         live_p_in = '1;
         live_r_in = '1;
         chg_in    = 1'b0;
      end else begin
         if (proc_hit) begin
            live_p_in[proc_row] = 1'b0;
         end
         if (res_hit) begin
            live_r_in[res_row] = 1'b0;
         end
         if (ctl.clear_chg) begin
            chg_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_p_ff <= '1;
         live_r_ff <= '1;
         chg_ff    <= 1'b0;
      end else begin
         live_p_ff <= live_p_in;
         live_r_ff <= live_r_in;
         chg_ff    <= chg_in;
      end
   end

   assign changed     = chg_ff | proc_hit | res_hit;
   assign cycle_found = (|live_p_ff) | (|live_r_ff);

endmodule

FILE: src/wait_graph_deadlock_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_graph_deadlock_detector
// Keeps the request and assignment bit matrices of a resource allocation
// graph and reports after every event whether the graph holds a cycle.
// ----------------------------------------------------------------------------
// One event is taken at a time: busy is high from the cycle after start until
// the verdict is out. An event that changes the matrices first does a
// read-modify-write of the row memories in ST_UPD_RD and ST_UPD_WR (none for
// an ignored event). The check then peels nodes off in passes; each pass reads
// every process row and every resource row through the one read port of each
// memory, one row a cycle, then ends in ST_SCAN_END. Passes repeat until one
// removes nothing, so a check takes one pass or more and at most
// NUM_PROCS + NUM_RESOURCES + 1 passes. The verdict shows on rsp_deadlock for
// one cycle with rsp_valid, in the cycle busy falls, and must be taken then:
// there is no backpressure. Both matrices read as zero after reset, with no
// clearing pass.
// ----------------------------------------------------------------------------
module wait_graph_deadlock_detector
   import wgdd_pkg::*;
#(
   parameter int NUM_PROCS     = DEF_NUM_PROCS,
   parameter int NUM_RESOURCES = DEF_NUM_RESOURCES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [PIDX_W-1:0] req_proc_index,
   input  logic [RIDX_W-1:0] req_resource_index,
   output logic              rsp_valid,
   output logic              rsp_deadlock
);

   localparam int PAW   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int RAW   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int NODES = NUM_PROCS + NUM_RESOURCES;
   localparam int CNTW  = $clog2(NODES);

   localparam logic [CNTW-1:0] LAST_IDX  = CNTW'(NODES - 1);
   localparam logic [CNTW-1:0] PROC_ROWS = CNTW'(NUM_PROCS);

   state_type state_ff, state_in;

   // captured event
   logic [MODE_W-1:0] mode_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic [RIDX_W-1:0] ridx_ff;

   // scan position and read pipeline
   logic [CNTW-1:0] idx_ff, idx_in;
   logic            pv_ff, pv_in;
   logic            rv_ff, rv_in;
   logic [PAW-1:0]  prow_ff;
   logic [RAW-1:0]  rrow_ff;

   // row valid flags: a row never written reads as zero
   logic [NUM_PROCS-1:0]     wrow_ok_ff;
   logic [NUM_RESOURCES-1:0] hrow_ok_ff;
   logic                     wok_ff;
   logic                     hok_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_deadlock_ff;

   // memory ports
   logic                     w_wr_en, w_rd_en;
   logic [PAW-1:0]           w_wr_addr, w_rd_addr;
   logic [NUM_RESOURCES-1:0] w_wr_data, w_rd_data, w_row;
   logic                     h_wr_en, h_rd_en;
   logic [RAW-1:0]           h_wr_addr, h_rd_addr;
   logic [NUM_PROCS-1:0]     h_wr_data, h_rd_data, h_row;

   logic [PAW-1:0]           ev_paddr;
   logic [RAW-1:0]           ev_raddr;
   logic [NUM_RESOURCES-1:0] rbit;
   logic [NUM_PROCS-1:0]     pbit;
   logic                     req_take;
   logic                     req_update;
   logic                     in_scan_proc;
   logic [CNTW-1:0]          res_off;

   peel_ctl_type peel_ctl;
   logic         peel_changed;
   logic         peel_cycle;

   assign req_take   = start && !busy;
   assign req_update = (32'(req_proc_index) < NUM_PROCS)
                    && (32'(req_resource_index) < NUM_RESOURCES)
                    && (req_mode != MODE_UNUSED);

   assign ev_paddr = PAW'(pidx_ff);
   assign ev_raddr = RAW'(ridx_ff);
   assign rbit     = NUM_RESOURCES'(1) << ridx_ff;
   assign pbit     = NUM_PROCS'(1) << pidx_ff;

   assign in_scan_proc = idx_ff < PROC_ROWS;
   assign res_off      = idx_ff - PROC_ROWS;

   // masked read data
   assign w_row = wok_ff ? w_rd_data : '0;
   assign h_row = hok_ff ? h_rd_data : '0;

   // row memories
   wgdd_ram #(
      .WIDTH (NUM_RESOURCES),
      .DEPTH (NUM_PROCS)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_en   (w_rd_en),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   wgdd_ram #(
      .WIDTH (NUM_PROCS),
      .DEPTH (NUM_RESOURCES)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   // live-node peeling
   wgdd_peel #(
      .NUM_PROCS     (NUM_PROCS),
      .NUM_RESOURCES (NUM_RESOURCES)
   ) u_peel (
      .clock       (clock),
      .reset       (reset),
      .ctl         (peel_ctl),
      .proc_row    (prow_ff),
      .res_row     (rrow_ff),
      .wait_row    (w_row),
      .held_row    (h_row),
      .changed     (peel_changed),
      .cycle_found (peel_cycle)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = req_update ? ST_UPD_RD : ST_SCAN;
            end
         end
         ST_UPD_RD:   state_in = ST_UPD_WR;
         ST_UPD_WR:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = peel_changed ? ST_SCAN : ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      w_rd_en      = 1'b0;
      w_rd_addr    = ev_paddr;
      h_rd_en      = 1'b0;
      h_rd_addr    = ev_raddr;
      w_wr_en      = 1'b0;
      w_wr_addr    = ev_paddr;
      w_wr_data    = w_row;
      h_wr_en      = 1'b0;
      h_wr_addr    = ev_raddr;
      h_wr_data    = h_row;
      idx_in       = idx_ff;
      pv_in        = 1'b0;
      rv_in        = 1'b0;
      rsp_valid_in = 1'b0;
      peel_ctl     = '{init: 1'b0, proc_vld: pv_ff, res_vld: rv_ff, clear_chg: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            peel_ctl.init = start;
            idx_in        = '0;
         end
         ST_UPD_RD: begin
            w_rd_en = 1'b1;
            h_rd_en = 1'b1;
         end
         ST_UPD_WR: begin
            unique case (mode_ff)
               MODE_REQUEST: begin
                  w_wr_en   = 1'b1;
                  w_wr_data = w_row | rbit;
               end
               MODE_ASSIGN: begin
                  w_wr_en   = 1'b1;
                  w_wr_data = w_row & ~rbit;
                  h_wr_en   = 1'b1;
                  h_wr_data = h_row | pbit;
               end
               MODE_RELEASE: begin
                  h_wr_en   = 1'b1;
                  h_wr_data = h_row & ~pbit;
               end
               default: begin
               end
            endcase
            peel_ctl.proc_vld = 1'b0;
            peel_ctl.res_vld  = 1'b0;
         end
         ST_SCAN: begin
            // one row read a cycle: processes first, then resources
            if (in_scan_proc) begin
               w_rd_en   = 1'b1;
               w_rd_addr = PAW'(idx_ff);
               pv_in     = 1'b1;
            end else begin
               h_rd_en   = 1'b1;
               h_rd_addr = RAW'(res_off);
               rv_in     = 1'b1;
            end
            idx_in = idx_ff + CNTW'(1);
         end
         ST_SCAN_END: begin
            idx_in             = '0;
            peel_ctl.clear_chg = 1'b1;
            rsp_valid_in       = !peel_changed;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         rv_ff        <= 1'b0;
         idx_ff       <= '0;
         wrow_ok_ff   <= '0;
         hrow_ok_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= pv_in;
         rv_ff        <= rv_in;
         idx_ff       <= idx_in;
         if (w_wr_en) begin
            wrow_ok_ff[w_wr_addr] <= 1'b1;
         end
         if (h_wr_en) begin
            hrow_ok_ff[h_wr_addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         pidx_ff <= req_proc_index;
         ridx_ff <= req_resource_index;
      end
      if (w_rd_en) begin
         wok_ff  <= wrow_ok_ff[w_rd_addr];
         prow_ff <= w_rd_addr;
      end
      if (h_rd_en) begin
         hok_ff  <= hrow_ok_ff[h_rd_addr];
         rrow_ff <= h_rd_addr;
      end
      if (rsp_valid_in) begin
         rsp_deadlock_ff <= peel_cycle;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_deadlock = rsp_deadlock_ff;

   // checks
   a_rsp_after_final_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SCAN_END))
      else $error("verdict without a final pass");

   a_rsp_frees_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("verdict shown while busy");

   a_take_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but block not busy");

   a_pass_end_follows_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_END) |-> $past(state_ff == ST_SCAN && idx_ff == LAST_IDX))
      else $error("pass ended early");

endmodule
